// ===== src/itd_pkg.sv =====
// ----------------------------------------------------------------------------
// itd_pkg
// Shared types, codes and decode helpers for the ADC/DAC bus transaction
// decoder.
// ----------------------------------------------------------------------------
package itd_pkg;

    // Bus event codes
    localparam logic [2:0] ACT_START      = 3'd0;
    localparam logic [2:0] ACT_STOP       = 3'd1;
    localparam logic [2:0] ACT_ADDR_WRITE = 3'd2;
    localparam logic [2:0] ACT_ADDR_READ  = 3'd3;
    localparam logic [2:0] ACT_DATA       = 3'd4;

    // Result kinds
    localparam logic [1:0] KIND_ADDR_OK  = 2'd0;
    localparam logic [1:0] KIND_ADDR_BAD = 2'd1;
    localparam logic [1:0] KIND_POINTER  = 2'd2;
    localparam logic [1:0] KIND_DATA     = 2'd3;

    // Targets
    localparam logic [4:0] TGT_NONE     = 5'd0;
    localparam logic [4:0] TGT_NOP      = 5'd1;
    localparam logic [4:0] TGT_GPIO_OUT = 5'd9;
    localparam logic [4:0] TGT_GPIO_IN  = 5'd10;
    localparam logic [4:0] TGT_RESET    = 5'd14;
    localparam logic [4:0] TGT_DAC_WR   = 5'd15;
    localparam logic [4:0] TGT_DAC_RD   = 5'd16;
    localparam logic [4:0] TGT_ADC      = 5'd17;
    localparam logic [4:0] TGT_MAX      = TGT_ADC;

    // Device addresses
    localparam logic [7:0] DEV_ADDR_A = 8'h10;
    localparam logic [7:0] DEV_ADDR_B = 8'h11;

    // Pointer modes (upper nibble)
    localparam logic [3:0] MODE_CONFIG   = 4'd0;
    localparam logic [3:0] MODE_DAC_WR   = 4'd1;
    localparam logic [3:0] MODE_ADC      = 4'd4;
    localparam logic [3:0] MODE_DAC_RD   = 4'd5;
    localparam logic [3:0] MODE_GPIO_RD  = 4'd6;
    localparam logic [3:0] MODE_REG_RD   = 4'd7;

    // Register select codes with special meaning
    localparam logic [3:0] SEL_NOP       = 4'd0;
    localparam logic [3:0] SEL_UNUSED    = 4'd1;
    localparam logic [3:0] SEL_RESERVED  = 4'd14;
    localparam logic [3:0] SEL_RESET     = 4'd15;

    // Word field masks
    localparam logic [15:0] MASK_CODE = 16'h0FFF;
    localparam logic [15:0] MASK_LOW  = 16'h07FF;
    localparam logic [15:0] MASK_CHAN = 16'h0007;
    localparam logic [15:0] MASK_LDAC = 16'h0003;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ADDR = 3'd1,
        PH_PTR  = 3'd2,
        PH_HIGH = 3'd3,
        PH_LOW  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  target;
        logic [3:0]  pointer_mode;
        logic [3:0]  pointer_channel;
        logic [15:0] data_word;
        logic [7:0]  pin_mask;
        logic [11:0] sample_code;
        logic [2:0]  word_channel;
        logic [10:0] low_field;
        logic [1:0]  load_mode;
        logic [6:0]  option_bits;
    } t_result;

    // Map a register select code to its target
    function automatic logic [4:0] sel_to_target(input logic [3:0] sel);
        logic [4:0] tgt;
        case (sel)
            SEL_NOP:    tgt = TGT_NOP;
            SEL_UNUSED: tgt = TGT_NONE;
            SEL_RESERVED: tgt = TGT_NONE;
            SEL_RESET:  tgt = TGT_RESET;
            default:    tgt = {1'b0, sel};
        endcase
        return tgt;
    endfunction

    // Decode a pointer byte into its target
    function automatic logic [4:0] decode_pointer(input logic [7:0] ptr,
                                                  input logic       rd_xfer);
        logic [3:0] mode;
        logic [3:0] chan;
        logic [4:0] tgt;
        mode = ptr[7:4];
        chan = ptr[3:0];
        case (mode)
            MODE_CONFIG:  tgt = sel_to_target(chan);
            MODE_DAC_WR:  tgt = TGT_DAC_WR;
            MODE_ADC:     tgt = TGT_ADC;
            MODE_DAC_RD:  tgt = TGT_DAC_RD;
            MODE_GPIO_RD: tgt = rd_xfer ? TGT_GPIO_OUT : TGT_GPIO_IN;
            MODE_REG_RD: begin
                if (chan inside {SEL_RESERVED, SEL_RESET}) begin
                    tgt = TGT_NONE;
                end else begin
                    tgt = sel_to_target(chan);
                end
            end
            default:      tgt = TGT_NONE;
        endcase
        return tgt;
    endfunction

endpackage

// ===== src/i2c_dac_adc_transaction_decoder.sv =====
// ----------------------------------------------------------------------------
// i2c_dac_adc_transaction_decoder
// Bus event decoder for register transactions on a 12-bit ADC/DAC device.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one bus event per item:
//   action code and the byte it carries. Output channel (o_out_valid /
//   i_out_stall) carries address, pointer and data word results.
//   An item is taken on a clock edge with valid high and stall low.
//   An accepted item sits in the input register, is decoded and lands in
//   the result register once that register is empty or its item is taken.
//   Events that give no result (start, stop, high data byte, unexpected
//   events) just update state.
//   Throughput: one item per cycle while the receiver does not stall, set by
//   the combinational decode between the input and result registers.
//   Stall: while the receiver stalls a full result register, the input
//   register holds its item and o_in_stall rises once it is full; the
//   result payload holds steady.
//   Reset: synchronous, active low; empties both registers and returns the
//   tracker to idle with no target selected.
// ----------------------------------------------------------------------------
module i2c_dac_adc_transaction_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_bus_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [4:0]  o_target,
    output logic [3:0]  o_pointer_mode,
    output logic [3:0]  o_pointer_channel,
    output logic [15:0] o_data_word,
    output logic [7:0]  o_pin_mask,
    output logic [11:0] o_sample_code,
    output logic [2:0]  o_word_channel,
    output logic [10:0] o_low_field,
    output logic [1:0]  o_load_mode,
    output logic [6:0]  o_option_bits
);
    import itd_pkg::*;

    logic       r_in_valid;
    logic [2:0] r_action;
    logic [7:0] r_bus_byte;

    logic    advance;
    logic    fire;
    logic    res_valid;
    t_result result;
    t_result out_result;

    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Input register payload
    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_action   <= i_action;
            r_bus_byte <= i_bus_byte;
        end
    end

    itd_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_action    (r_action),
        .i_bus_byte  (r_bus_byte),
        .o_res_valid (res_valid),
        .o_result    (result)
    );

    itd_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load_valid (r_in_valid),
        .i_res_valid  (res_valid),
        .i_result     (result),
        .i_out_stall  (i_out_stall),
        .o_advance    (advance),
        .o_out_valid  (o_out_valid),
        .o_result     (out_result)
    );

    // Unpack result fields
    assign o_kind            = out_result.kind;
    assign o_target          = out_result.target;
    assign o_pointer_mode    = out_result.pointer_mode;
    assign o_pointer_channel = out_result.pointer_channel;
    assign o_data_word       = out_result.data_word;
    assign o_pin_mask        = out_result.pin_mask;
    assign o_sample_code     = out_result.sample_code;
    assign o_word_channel    = out_result.word_channel;
    assign o_low_field       = out_result.low_field;
    assign o_load_mode       = out_result.load_mode;
    assign o_option_bits     = out_result.option_bits;

endmodule

// ===== src/itd_decode.sv =====
// ----------------------------------------------------------------------------
// itd_decode
// Transaction phase tracker and single-pass event decode. Holds the
// transaction state and forms the result for the item in the input register.
// ----------------------------------------------------------------------------
module itd_decode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic [2:0]        i_action,
    input  logic [7:0]        i_bus_byte,
    output logic              o_res_valid,
    output itd_pkg::t_result  o_result
);
    import itd_pkg::*;

    t_phase     r_phase, n_phase;
    logic       r_read_transfer, n_read_transfer;
    logic [4:0] r_selected_target, n_selected_target;
    logic [7:0] r_high_byte, n_high_byte;

    logic [15:0] word;
    logic [4:0]  ptr_target;
    logic        addr_ok;

    assign word       = {r_high_byte, i_bus_byte};
    assign ptr_target = decode_pointer(i_bus_byte, r_read_transfer);
    assign addr_ok    = (i_bus_byte == DEV_ADDR_A) || (i_bus_byte == DEV_ADDR_B);

    // State registers, advance only when the item is consumed
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase           <= PH_IDLE;
            r_read_transfer   <= 1'b0;
            r_selected_target <= TGT_NONE;
            r_high_byte       <= 8'd0;
        end else if (i_fire) begin
            r_phase           <= n_phase;
            r_read_transfer   <= n_read_transfer;
            r_selected_target <= n_selected_target;
            r_high_byte       <= n_high_byte;
        end
    end

    // Next state and result
    always_comb begin
        n_phase           = r_phase;
        n_read_transfer   = r_read_transfer;
        n_selected_target = r_selected_target;
        n_high_byte       = r_high_byte;
        o_res_valid       = 1'b0;
        o_result          = '0;

        if (i_action == ACT_STOP) begin
            n_phase = PH_IDLE;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                    if (i_action == ACT_START) begin
                        n_phase = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (i_action == ACT_ADDR_WRITE || i_action == ACT_ADDR_READ) begin
                        o_res_valid   = 1'b1;
                        o_result.kind = addr_ok ? KIND_ADDR_OK : KIND_ADDR_BAD;
                        if (i_action == ACT_ADDR_WRITE) begin
                            n_read_transfer = 1'b0;
                            n_phase         = PH_PTR;
                        end else begin
                            n_read_transfer = 1'b1;
                            n_phase         = PH_HIGH;
                        end
                    end
                end
                PH_PTR: begin
                    if (i_action == ACT_DATA) begin
                        o_res_valid              = 1'b1;
                        n_selected_target        = ptr_target;
                        o_result.kind            = KIND_POINTER;
                        o_result.target          = ptr_target;
                        o_result.pointer_mode    = i_bus_byte[7:4];
                        o_result.pointer_channel = i_bus_byte[3:0];
                        n_phase                  = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (i_action == ACT_DATA) begin
                        n_high_byte = i_bus_byte;
                        n_phase     = PH_LOW;
                    end
                end
                PH_LOW: begin
                    if (i_action == ACT_DATA) begin
                        o_res_valid           = 1'b1;
                        o_result.kind         = KIND_DATA;
                        o_result.target       = r_selected_target;
                        o_result.data_word    = word;
                        o_result.pin_mask     = word[7:0];
                        o_result.sample_code  = 12'(word & MASK_CODE);
                        o_result.word_channel = 3'((word >> 12) & MASK_CHAN);
                        o_result.low_field    = 11'(word & MASK_LOW);
                        o_result.load_mode    = 2'(word & MASK_LDAC);
                        o_result.option_bits  = word[10:4];
                        n_phase               = PH_HIGH;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/itd_out_reg.sv =====
// ----------------------------------------------------------------------------
// itd_out_reg
// Result register on the output channel. Loads a new result whenever it is
// empty or its current item is being taken.
// ----------------------------------------------------------------------------
module itd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load_valid,
    input  logic              i_res_valid,
    input  itd_pkg::t_result  i_result,
    input  logic              i_out_stall,
    output logic              o_advance,
    output logic              o_out_valid,
    output itd_pkg::t_result  o_result
);
    import itd_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_advance   = !r_valid || !i_out_stall;
    assign o_out_valid = r_valid;
    assign o_result    = r_result;

    // Valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load_valid && i_res_valid;
        end
    end

    // Payload, hold while stalled
    always_ff @(posedge i_clk) begin
        if (o_advance && i_load_valid && i_res_valid) begin
            r_result <= i_result;
        end
    end

endmodule

// ===== src/itd_checker.sv =====
// ----------------------------------------------------------------------------
// itd_checker
// Port-level checks on the transaction decoder, bound to the top level.
// ----------------------------------------------------------------------------
module itd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_kind,
    input logic [4:0]  o_target,
    input logic [3:0]  o_pointer_mode,
    input logic [3:0]  o_pointer_channel,
    input logic [15:0] o_data_word,
    input logic [11:0] o_sample_code,
    input logic [6:0]  o_option_bits
);
    import itd_pkg::*;

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // Stalled item holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_kind) && $stable(o_target) && $stable(o_data_word))
        else $error("stalled item changed");

    // Address items carry no target or word
    a_addr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == KIND_ADDR_OK || o_kind == KIND_ADDR_BAD) |->
            o_target == TGT_NONE && o_data_word == 16'd0 && o_pointer_mode == 4'd0)
        else $error("address item has nonzero fields");

    // Pointer items carry no word and a legal target
    a_ptr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_POINTER |->
            o_data_word == 16'd0 && o_target <= TGT_MAX)
        else $error("pointer item malformed");

    // Data items split the word consistently
    a_data_split: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_kind == KIND_DATA |->
            o_sample_code == o_data_word[11:0] && o_option_bits == o_data_word[10:4]
            && o_pointer_mode == 4'd0 && o_pointer_channel == 4'd0)
        else $error("data item fields inconsistent");

endmodule

bind i2c_dac_adc_transaction_decoder itd_checker u_itd_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_kind            (o_kind),
    .o_target          (o_target),
    .o_pointer_mode    (o_pointer_mode),
    .o_pointer_channel (o_pointer_channel),
    .o_data_word       (o_data_word),
    .o_sample_code     (o_sample_code),
    .o_option_bits     (o_option_bits)
);
